/* src/npr_pkg.sv */
// Package for the nearest point within radius search.
// Holds opcodes, widths and the result word type; depends on nothing.
`default_nettype none
package npr_pkg;
  localparam int unsigned FixedDepthDef = 32;
  localparam int unsigned UserDepthDef = 32;
  localparam int unsigned CoordBitsDef = 24;
  localparam int unsigned CoordW = CoordBitsDef;
  localparam int unsigned RadW = 23;
  localparam int unsigned DistW = 50;
  localparam int unsigned IdxW = 5;

  localparam logic [2:0] OpAddFixed = 3'd0;
  localparam logic [2:0] OpAddUser = 3'd1;
  localparam logic [2:0] OpClear = 3'd2;
  localparam logic [2:0] OpNearest = 3'd3;
  localparam logic [2:0] OpAll = 3'd4;

  typedef struct packed {
    logic found;
    logic which_table;
    logic [IdxW-1:0] entry_index;
    logic [DistW-1:0] distance_sq;
    logic status;
    logic last;
  } res_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic signed [CoordW-1:0] x_coord;
    logic signed [CoordW-1:0] y_coord;
    logic [RadW-1:0] radius;
  } req_t;
endpackage
`default_nettype wire

/* src/npr_if.sv */
// Valid/ready channel interface for the search block.
// Depends on npr_pkg for nothing but is generic over the payload type.
`default_nettype none
interface npr_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/npr_cell.sv */
// One storage cell of a point table: holds a point, with no valid flag.
// Registers the squared distance of its point to the query; uses npr_pkg.
`default_nettype none
module npr_cell import npr_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic clk_i,
  input  wire logic we_i,
  input  wire logic signed [CoordBits-1:0] wx_i,
  input  wire logic signed [CoordBits-1:0] wy_i,
  input  wire logic signed [CoordBits-1:0] qx_i,
  input  wire logic signed [CoordBits-1:0] qy_i,
  output logic [2*CoordBits+1:0] dist_o
);
  logic signed [CoordBits-1:0] px_q, py_q;
  logic signed [CoordBits:0] dx, dy;
  logic [CoordBits:0] ax, ay;
  logic [2*CoordBits+1:0] sx, sy;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      px_q <= wx_i;
      py_q <= wy_i;
    end
  end

  always_comb begin
    dx = {px_q[CoordBits-1], px_q} - {qx_i[CoordBits-1], qx_i};
    dy = {py_q[CoordBits-1], py_q} - {qy_i[CoordBits-1], qy_i};
    ax = dx[CoordBits] ? -dx : dx;
    ay = dy[CoordBits] ? -dy : dy;
    sx = {{(CoordBits+1){1'b0}}, ax} * {{(CoordBits+1){1'b0}}, ax};
    sy = {{(CoordBits+1){1'b0}}, ay} * {{(CoordBits+1){1'b0}}, ay};
  end

  always_ff @(posedge clk_i) begin
    dist_o <= {1'b0, sx[2*CoordBits:0]} + {1'b0, sy[2*CoordBits:0]};
  end
endmodule
`default_nettype wire

/* src/nearest_point_within_radius.sv */
// Top level of the nearest point within radius search.
// Uses npr_pkg, npr_if and two tables of npr_cell point cells.
//
// Usage: in_i is a sink channel of req_t words (opcode, x, y, radius); out_o
// is a source channel of res_t words. An add or clear gives one word, which
// is in the output register at the accepting edge. A query walks the fixed
// table then the user table, one stored point per cycle while the output is
// free, and its final word is registered after a warm-up step for the cells
// to register their distances, a step past the end of each table, and a step
// to form the final word. Each cell registers its own squared distance, one
// multiplier pair per cell; the scan index selects one registered distance
// per cycle.
// Nearest returns one word; all-in-radius returns one word per hit with last
// set on the final one, or one miss word. One item is worked at a time; the
// next is accepted once the final word has entered the output register and
// the output is free again. When the receiver stalls, the scan halts with
// the pending word held. Reset empties both tables and the output register;
// stored points are not cleared and are only read below the counts.
`default_nettype none
module nearest_point_within_radius import npr_pkg::*; #(
  parameter int unsigned FixedDepth = FixedDepthDef,
  parameter int unsigned UserDepth = UserDepthDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  npr_if.sink   in_i,
  npr_if.source out_o
);
  localparam int unsigned CoordBits = CoordW;
  localparam int unsigned DW = 2*CoordBits + 2;
  localparam int unsigned BW = (DW > 2*RadW) ? DW : 2*RadW;
  localparam int unsigned SW = (DW > DistW) ? DW : DistW;

  typedef enum logic [2:0] {
    StIdle = 3'b001, StScan = 3'b010, StEnd = 3'b100
  } st_e;

  st_e st_q, st_d;
  logic [2:0] op_q, op_d;
  logic signed [CoordBits-1:0] qx_q, qy_q, qx_d, qy_d;
  logic [BW-1:0] bound_q, bound_d;
  logic [5:0] fcnt_q, ucnt_q, fcnt_d, ucnt_d;
  logic tab_q, tab_d;
  logic [5:0] idx_q, idx_d;
  logic hit_q, bt_q, hit_d, bt_d;
  logic [IdxW-1:0] bi_q, bi_d;
  logic [DW-1:0] bd_q, bd_d;
  logic ovalid_q, ovalid_d;
  res_t ores_q, ores_d;
  logic [DW-1:0] fdist [FixedDepth];
  logic [DW-1:0] udist [UserDepth];
  logic [DW-1:0] cur_d;
  logic warm_q, warm_d;

  logic signed [CoordBits-1:0] in_x, in_y;
  assign in_x = in_i.payload.x_coord[CoordBits-1:0];
  assign in_y = in_i.payload.y_coord[CoordBits-1:0];

  logic [2*RadW-1:0] rad_sq;
  assign rad_sq = {{RadW{1'b0}}, in_i.payload.radius} * {{RadW{1'b0}}, in_i.payload.radius};

  logic in_fire, out_free;
  assign out_free = !ovalid_q || out_o.ready;
  assign in_i.ready = (st_q == StIdle) && out_free;
  assign in_fire = in_i.valid && in_i.ready;
  assign out_o.valid = ovalid_q;
  assign out_o.payload = ores_q;

  for (genvar g = 0; g < FixedDepth; g++) begin : g_fix
    npr_cell #(.CoordBits(CoordBits)) u_cell (
      .clk_i, .we_i(in_fire && in_i.payload.opcode == OpAddFixed && fcnt_q == 6'(g)),
      .wx_i(in_x), .wy_i(in_y), .qx_i(qx_q), .qy_i(qy_q), .dist_o(fdist[g]));
  end
  for (genvar g = 0; g < UserDepth; g++) begin : g_usr
    npr_cell #(.CoordBits(CoordBits)) u_cell (
      .clk_i, .we_i(in_fire && in_i.payload.opcode == OpAddUser && ucnt_q == 6'(g)),
      .wx_i(in_x), .wy_i(in_y), .qx_i(qx_q), .qy_i(qy_q), .dist_o(udist[g]));
  end

  localparam int unsigned FIW = (FixedDepth > 1) ? $clog2(FixedDepth) : 1;
  localparam int unsigned UIW = (UserDepth > 1) ? $clog2(UserDepth) : 1;
  always_comb begin
    if (!tab_q) cur_d = fdist[idx_q[FIW-1:0]];
    else cur_d = udist[idx_q[UIW-1:0]];
  end

  logic in_tab, hit_now;
  logic [5:0] tcnt;
  logic [DistW-1:0] bd_sat;
  assign tcnt = tab_q ? ucnt_q : fcnt_q;
  assign in_tab = idx_q < tcnt;
  assign hit_now = in_tab && (BW'(cur_d) <= bound_q);
  assign bd_sat = (SW'(bd_q) > SW'({DistW{1'b1}})) ? {DistW{1'b1}} : DistW'(bd_q);

  always_comb begin
    st_d = st_q;
    op_d = op_q;
    qx_d = qx_q;
    qy_d = qy_q;
    bound_d = bound_q;
    fcnt_d = fcnt_q;
    ucnt_d = ucnt_q;
    tab_d = tab_q;
    idx_d = idx_q;
    hit_d = hit_q;
    bt_d = bt_q;
    bi_d = bi_q;
    bd_d = bd_q;
    warm_d = warm_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ores_d = ores_q;
    case (st_q)
      StIdle: begin
        if (in_fire) begin
          ovalid_d = 1'b1;
          ores_d = '0;
          ores_d.last = 1'b1;
          case (in_i.payload.opcode)
            OpAddFixed: begin
              if (fcnt_q >= 6'(FixedDepth)) ores_d.status = 1'b1;
              else begin
                ores_d.entry_index = fcnt_q[IdxW-1:0];
                fcnt_d = fcnt_q + 6'd1;
              end
            end
            OpAddUser: begin
              ores_d.which_table = 1'b1;
              if (ucnt_q >= 6'(UserDepth)) ores_d.status = 1'b1;
              else begin
                ores_d.entry_index = ucnt_q[IdxW-1:0];
                ucnt_d = ucnt_q + 6'd1;
              end
            end
            OpClear: begin
              fcnt_d = '0;
              ucnt_d = '0;
            end
            OpNearest, OpAll: begin
              ovalid_d = 1'b0;
              st_d = StScan;
              warm_d = 1'b0;
            end
            default: ;
          endcase
          op_d = in_i.payload.opcode;
          qx_d = in_x;
          qy_d = in_y;
          bound_d = BW'(rad_sq);
          tab_d = 1'b0;
          idx_d = '0;
          hit_d = 1'b0;
        end
      end
      StScan: begin
        if (!warm_q) warm_d = 1'b1;
        else if (out_free) begin
          if (hit_now) begin
            hit_d = 1'b1;
            bt_d = tab_q;
            bi_d = idx_q[IdxW-1:0];
            bd_d = cur_d;
            if (op_q == OpNearest) bound_d = BW'(cur_d);
            else if (hit_q) begin
              ovalid_d = 1'b1;
              ores_d = '{1'b1, bt_q, bi_q, bd_sat, 1'b0, 1'b0};
            end
          end
          if (!in_tab) begin
            if (tab_q) st_d = StEnd;
            else begin
              tab_d = 1'b1;
              idx_d = '0;
            end
          end else idx_d = idx_q + 6'd1;
        end
      end
      StEnd: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          st_d = StIdle;
          if (hit_q) ores_d = '{1'b1, bt_q, bi_q, bd_sat, 1'b0, 1'b1};
          else ores_d = '{1'b0, 1'b0, '0, '0, 1'b0, 1'b1};
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      op_q <= '0;
      qx_q <= '0;
      qy_q <= '0;
      bound_q <= '0;
      fcnt_q <= '0;
      ucnt_q <= '0;
      tab_q <= 1'b0;
      idx_q <= '0;
      hit_q <= 1'b0;
      bt_q <= 1'b0;
      bi_q <= '0;
      bd_q <= '0;
      warm_q <= 1'b0;
      ovalid_q <= 1'b0;
      ores_q <= '0;
    end else begin
      st_q <= st_d;
      op_q <= op_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
      bound_q <= bound_d;
      fcnt_q <= fcnt_d;
      ucnt_q <= ucnt_d;
      tab_q <= tab_d;
      idx_q <= idx_d;
      hit_q <= hit_d;
      bt_q <= bt_d;
      bi_q <= bi_d;
      bd_q <= bd_d;
      warm_q <= warm_d;
      ovalid_q <= ovalid_d;
      ores_q <= ores_d;
    end
  end

  a_cnt_f: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= 6'(FixedDepth)) else $error("fixed count overflow");
  a_cnt_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ucnt_q <= 6'(UserDepth)) else $error("user count overflow");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> !in_i.ready) else $error("accept during scan");
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StEnd && out_free) |=> ovalid_q && ores_q.last) else $error("no final word");
endmodule
`default_nettype wire
